// ===== hdl/trace_gain_demean_gapfill_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trace gain/demean/gap-fill block
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TRACE_GAIN_DEMEAN_GAPFILL_ASSERT_SVH
`define TRACE_GAIN_DEMEAN_GAPFILL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGDG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGDG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tgdg_pkg.sv =====
// ----------------------------------------------------------------------------
// tgdg_pkg
// Shared constants for the trace gain/demean/gap-fill block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tgdg_pkg;

  // Default sizing of the trace store and the input sample.
  localparam int unsigned MAX_SAMPLES_DEF = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Gain register: unsigned Q8.16, reset to 1.0.
  localparam int unsigned GAIN_BITS      = 24;
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'h010000;

  // Result value and its byte-padded stream width.
  localparam int unsigned VALUE_BITS   = 34;
  localparam int unsigned M_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  // floor(n / 10) as (n * DIV10_MULT) >> DIV10_SHIFT, exact for n below 2^18.
  localparam int unsigned DIV10_MULT  = 52429;
  localparam int unsigned DIV10_SHIFT = 19;

endpackage

`default_nettype wire

// ===== hdl/trace_gain_demean_gapfill.sv =====
// ----------------------------------------------------------------------------
// trace_gain_demean_gapfill
// Collects one trace, scales it by a Q8.16 gain, then streams it out with the
// head-window mean removed, and gaps and zero scaled values set to that mean.
// ----------------------------------------------------------------------------
// A trace is loaded one sample per cycle until the transfer marked with tlast;
// the input then stops taking data while the trace is processed. The cycle
// after the last transfer stores that sample. The block then finds the head
// window (n/10, or n), sums it through the single store read port, and sets
// up and runs the bit-serial divider that forms the mean (skipped when the
// head holds only gaps). Each result is then one store read followed by one
// subtract, and waits while the output is stalled. The last result may still
// wait on the output while the next trace loads.
`default_nettype none

module trace_gain_demean_gapfill #(
  parameter int unsigned MAX_SAMPLES = tgdg_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = tgdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Gain register write
  input  logic                                 cfg_we_i,
  input  logic [tgdg_pkg::GAIN_BITS-1:0]       cfg_wdata_i,
  // Sample input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample, zero padded
  input  logic                                 s_axis_tuser,  // is_gap
  input  logic                                 s_axis_tlast,  // last_sample
  // Result output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [tgdg_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,  // value, zero padded
  output logic                                 m_axis_tuser,  // mean_fault
  output logic                                 m_axis_tlast   // last_result
);

  localparam int unsigned GAIN_BITS   = tgdg_pkg::GAIN_BITS;
  localparam int unsigned VALUE_BITS  = tgdg_pkg::VALUE_BITS;
  localparam int unsigned SCALED_BITS = SAMPLE_BITS + GAIN_BITS - tgdg_pkg::GAIN_FRAC_BITS;
  localparam int unsigned PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int unsigned MEM_BITS    = SCALED_BITS + 1;
  localparam int unsigned CNT_BITS    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ADDR_BITS   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned SUM_BITS    = SCALED_BITS + CNT_BITS;
  localparam int unsigned REM_BITS    = CNT_BITS + 1;
  localparam int unsigned DCNT_BITS   = $clog2(SUM_BITS);
  localparam int unsigned HPROD_BITS  = CNT_BITS + tgdg_pkg::DIV10_SHIFT + 1;
  localparam int unsigned EXT_BITS    = (SCALED_BITS + 1 > VALUE_BITS) ?
                                        SCALED_BITS + 1 : VALUE_BITS;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_HEAD  = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_DPREP = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_DFIN  = 8'b0010_0000,
    ST_EMRD  = 8'b0100_0000,
    ST_EMLD  = 8'b1000_0000
  } state_e;

  state_e                        state_q, state_d;
  logic [GAIN_BITS-1:0]          gain_q;

  // Input capture stage
  logic                          s1_vld_q, s1_vld_d;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                          s1_gap_q;
  logic                          s1_last_q;

  // Trace bookkeeping
  logic [CNT_BITS-1:0]           count_q, count_d;
  logic [CNT_BITS-1:0]           head_q, head_d;
  logic [CNT_BITS-1:0]           idx_q, idx_d;
  logic [CNT_BITS-1:0]           gaps_q, gaps_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;

  // Divider
  logic                          neg_q, neg_d;
  logic [SUM_BITS-1:0]           dvd_q, dvd_d;
  logic [REM_BITS-1:0]           rem_q, rem_d;
  logic [CNT_BITS-1:0]           divisor_q, divisor_d;
  logic [DCNT_BITS-1:0]          dcnt_q, dcnt_d;
  logic signed [SCALED_BITS-1:0] mean_q, mean_d;
  logic                          fault_q, fault_d;

  // Output register
  logic                          out_vld_q, out_vld_d;
  logic [VALUE_BITS-1:0]         out_value_q, out_value_d;
  logic                          out_last_q, out_last_d;
  logic                          out_fault_q, out_fault_d;

  // Store
  logic [MEM_BITS-1:0]           mem [MAX_SAMPLES];
  logic                          wr_en;
  logic [MEM_BITS-1:0]           wr_data;
  logic                          rd_en;
  logic [MEM_BITS-1:0]           rd_data_q;
  logic                          rd_vld_q, rd_vld_d;

  // Datapath helpers
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   prod_sh;
  logic [HPROD_BITS-1:0]         hprod;
  logic [CNT_BITS-1:0]           head_tenth;
  logic signed [SCALED_BITS-1:0] rd_sx;
  logic signed [EXT_BITS-1:0]    res_ext;
  logic [CNT_BITS-1:0]           valid_cnt;
  logic [REM_BITS-1:0]           trial;
  logic                          fits;
  logic [SCALED_BITS-1:0]        quot;

  // Gain scaling: floor(sample * gain / 2^16) by arithmetic shift.
  assign prod    = s1_sample_q * $signed({1'b0, gain_q});
  assign prod_sh = prod >>> tgdg_pkg::GAIN_FRAC_BITS;
  assign wr_en   = s1_vld_q && (count_q < CNT_BITS'(MAX_SAMPLES));
  assign wr_data = s1_gap_q ? {1'b1, {SCALED_BITS{1'b0}}}
                            : {1'b0, prod_sh[SCALED_BITS-1:0]};

  // Head window length as a reciprocal multiply.
  assign hprod      = HPROD_BITS'(count_q) * HPROD_BITS'(tgdg_pkg::DIV10_MULT);
  assign head_tenth = hprod[tgdg_pkg::DIV10_SHIFT +: CNT_BITS];

  // Store read word, demean result, divider step.
  assign rd_sx     = rd_data_q[SCALED_BITS-1:0];
  assign res_ext   = (rd_sx != '0) ? (EXT_BITS'(rd_sx) - EXT_BITS'(mean_q))
                                   : EXT_BITS'(mean_q);
  assign valid_cnt = head_q - gaps_q;
  assign trial     = {rem_q[REM_BITS-2:0], dvd_q[SUM_BITS-1]};
  assign fits      = trial >= {1'b0, divisor_q};
  assign quot      = dvd_q[SCALED_BITS-1:0];

  assign s_axis_tready = (state_q == ST_LOAD) && !(s1_vld_q && s1_last_q);
  assign s1_vld_d      = s_axis_tvalid && s_axis_tready;

  // Sequencer and shared datapath.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    idx_d       = idx_q;
    gaps_d      = gaps_q;
    sum_d       = sum_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    divisor_d   = divisor_q;
    dcnt_d      = dcnt_q;
    mean_d      = mean_q;
    fault_d     = fault_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_fault_d = out_fault_q;
    rd_en       = 1'b0;
    rd_vld_d    = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (s1_vld_q) begin
          if (wr_en) begin
            count_d = count_q + 1'b1;
          end
          if (s1_last_q) begin
            state_d = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        head_d  = (head_tenth == '0) ? count_q : head_tenth;
        idx_d   = '0;
        sum_d   = '0;
        gaps_d  = '0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        // One store read per cycle; data arrives in the next cycle.
        rd_en    = idx_q < head_q;
        rd_vld_d = rd_en;
        if (rd_en) begin
          idx_d = idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (rd_data_q[MEM_BITS-1]) begin
            gaps_d = gaps_q + 1'b1;
          end else begin
            sum_d = sum_q + SUM_BITS'(rd_sx);
          end
        end
        if (!rd_en && !rd_vld_q) begin
          state_d = ST_DPREP;
        end
      end
      ST_DPREP: begin
        idx_d = '0;
        if (valid_cnt == '0) begin
          // Head held only gaps: mean is zero and the trace is flagged.
          fault_d = 1'b1;
          mean_d  = '0;
          state_d = ST_EMRD;
        end else begin
          fault_d   = 1'b0;
          neg_d     = sum_q[SUM_BITS-1];
          dvd_d     = sum_q[SUM_BITS-1] ? (SUM_BITS'(0) - sum_q) : sum_q;
          rem_d     = '0;
          divisor_d = valid_cnt;
          dcnt_d    = DCNT_BITS'(SUM_BITS - 1);
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_d  = fits ? (trial - {1'b0, divisor_q}) : trial;
        dvd_d  = {dvd_q[SUM_BITS-2:0], fits};
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: begin
        // Truncation toward zero: divide magnitudes, then restore the sign.
        mean_d  = neg_q ? (SCALED_BITS'(0) - quot) : quot;
        state_d = ST_EMRD;
      end
      ST_EMRD: begin
        if (!out_vld_q || m_axis_tready) begin
          rd_en   = 1'b1;
          state_d = ST_EMLD;
        end
      end
      ST_EMLD: begin
        out_vld_d   = 1'b1;
        out_value_d = res_ext[VALUE_BITS-1:0];
        out_last_d  = (idx_q + 1'b1) == count_q;
        out_fault_d = fault_q;
        idx_d       = idx_q + 1'b1;
        if ((idx_q + 1'b1) == count_q) begin
          count_d = '0;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_EMRD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      gain_q    <= tgdg_pkg::GAIN_RESET;
      s1_vld_q  <= 1'b0;
      count_q   <= '0;
      idx_q     <= '0;
      dcnt_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_vld_q  <= s1_vld_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      dcnt_q    <= dcnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_vld_d) begin
      s1_sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
      s1_gap_q    <= s_axis_tuser;
      s1_last_q   <= s_axis_tlast;
    end
    head_q      <= head_d;
    gaps_q      <= gaps_d;
    sum_q       <= sum_d;
    neg_q       <= neg_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    divisor_q   <= divisor_d;
    mean_q      <= mean_d;
    fault_q     <= fault_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_fault_q <= out_fault_d;
  end

  // Trace store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[ADDR_BITS-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q[ADDR_BITS-1:0]];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = tgdg_pkg::M_TDATA_BITS'(out_value_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fault_q;

endmodule

`default_nettype wire

// ===== hdl/tgdg_checker.sv =====
// ----------------------------------------------------------------------------
// tgdg_checker
// Port-level checks of the trace gain/demean/gap-fill block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trace_gain_demean_gapfill_assert.svh"

module tgdg_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              s_axis_tlast,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [tgdg_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
  input wire logic                              m_axis_tuser,
  input wire logic                              m_axis_tlast
);

  // A stalled result holds its payload.
  `TGDG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

  // The transfer that closes a trace stops the input as soon as it is captured.
  `TGDG_ASSERT_NEXT(a_last_stops_input, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input still ready after the last sample")

  // No loading while a trace is still being emitted.
  `TGDG_ASSERT_NOW(a_no_load_in_emit, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during emission")

  // Each result but the last needs a store read before the next one shows.
  `TGDG_ASSERT_NEXT(a_emit_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid, "result followed without a store read")

endmodule

bind trace_gain_demean_gapfill tgdg_checker u_tgdg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
